// ===== rtl/dtc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the delimited token classifier.
package dtc_pkg;

   localparam int MAX_TOKENS     = 16;
   localparam int TOKEN_BUF_SIZE = 256;

   localparam int CHAR_W   = 8;
   localparam int INDEX_W  = 5;
   localparam int VALUE_W  = 32;
   localparam int LENGTH_W = 8;
   localparam int COUNT_W  = $clog2(MAX_TOKENS + 1);
   localparam int CURLEN_W = $clog2(TOKEN_BUF_SIZE);
   localparam int ACC_W    = 64;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_W      = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_CNT_W      = $clog2(RSP_FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_DEC = 2'd0,
      KIND_HEX = 2'd1,
      KIND_STR = 2'd2,
      KIND_SUM = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_TOO_MANY = 2'd1,
      ST_TOO_LONG = 2'd2
   } status_type;

   typedef struct packed {
      kind_type              kind;
      logic [INDEX_W-1:0]    token_index;
      logic [VALUE_W-1:0]    number_value;
      logic [LENGTH_W-1:0]   token_length;
      status_type            status;
      logic                  end_flag;
   } rsp_item_type;

   typedef struct packed {
      logic         first_valid;
      logic         second_valid;
      rsp_item_type first;
      rsp_item_type second;
   } emit_type;

   typedef struct packed {
      logic neg;
      logic bad;
      logic ovf;
      logic dig;
   } dec_flags_type;

   typedef struct packed {
      logic bad;
      logic ovf;
   } hex_flags_type;

endpackage

// ===== rtl/dtc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the byte input and the result output.
interface dtc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       last_byte;

   modport source (output valid, output char_in, output last_byte, input ready);
   modport sink (input valid, input char_in, input last_byte, output ready);
endinterface

interface dtc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [4:0]  token_index;
   logic [31:0] number_value;
   logic [7:0]  token_length;
   logic [1:0]  status;
   logic        end_flag;

   modport source (output valid, output kind, output token_index, output number_value,
                   output token_length, output status, output end_flag, input ready);
   modport sink (input valid, input kind, input token_index, input number_value,
                 input token_length, input status, input end_flag, output ready);
endinterface

// ===== rtl/delimited_token_classifier.sv =====
`timescale 1ns / 1ps
// Top level of the delimited token classifier: byte channel in, token result channel out.
// Every byte is classified combinationally against the token state as it is accepted;
// a new byte is accepted each cycle while the four-entry result queue has room for two
// items. A byte yields zero, one or two result items (a closing token and the end summary
// on the last byte), and the output side delivers one item per cycle, so a stream runs at
// one byte per cycle unless the consumer stalls or last bytes arrive back to back. The
// longest path is the 64-bit times-ten add of the decimal recognizer and its overflow test.
module delimited_token_classifier (
   input logic        clock,
   input logic        reset,
   dtc_req_if.sink    req_ch,
   dtc_rsp_if.source  rsp_ch
);
   import dtc_pkg::*;

   emit_type     emit;
   rsp_item_type out_item;
   logic         space_ok;
   logic         accept;

   assign req_ch.ready = space_ok && !reset;
   assign accept       = req_ch.valid && req_ch.ready;

   dtc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_in   (req_ch.char_in),
      .last_byte (req_ch.last_byte),
      .emit      (emit)
   );

   dtc_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .space_ok  (space_ok),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_item  (out_item)
   );

   assign rsp_ch.kind         = out_item.kind;
   assign rsp_ch.token_index  = out_item.token_index;
   assign rsp_ch.number_value = out_item.number_value;
   assign rsp_ch.token_length = out_item.token_length;
   assign rsp_ch.status       = out_item.status;
   assign rsp_ch.end_flag     = out_item.end_flag;

endmodule

// ===== rtl/dtc_core.sv =====
`timescale 1ns / 1ps
// Tokenizer state and per-byte classification; emits up to two result items per byte.
module dtc_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [dtc_pkg::CHAR_W-1:0] char_in,
   input  logic                      last_byte,
   output dtc_pkg::emit_type         emit
);
   import dtc_pkg::*;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LF_HEX = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
   localparam logic [ACC_W-1:0]  DEC_MUL_LIMIT = 64'd922337203685477580;
   localparam logic [4:0]        HEX_NONE = 5'd16;
   localparam logic [COUNT_W-1:0]  MAX_COUNT  = COUNT_W'(MAX_TOKENS);
   localparam logic [CURLEN_W-1:0] MAX_CURLEN = CURLEN_W'(TOKEN_BUF_SIZE - 1);
   localparam logic [CURLEN_W-1:0] HEX_MIN_LEN = CURLEN_W'(2);

   function automatic logic is_delim(input logic [CHAR_W-1:0] c);
      is_delim = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR) ||
                 (c == CHAR_COMMA) || (c == CHAR_COLON) || (c == CHAR_NUL);
   endfunction

   function automatic logic [4:0] hex_value(input logic [CHAR_W-1:0] c);
      logic [4:0] v;
      v = HEX_NONE;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         v = {1'b0, c[3:0]};
      end else if ((c >= CHAR_LA && c <= CHAR_LF_HEX) || (c >= CHAR_UA && c <= CHAR_UF)) begin
         v = 5'({1'b0, c[3:0]} + 5'd9);
      end
      return v;
   endfunction

   logic                in_token_ff, in_token_in;
   logic [CURLEN_W-1:0] cur_length_ff, cur_length_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [ACC_W-1:0]    dec_mag_ff, dec_mag_in;
   dec_flags_type       dec_flags_ff, dec_flags_in;
   logic [ACC_W-1:0]    hex_acc_ff, hex_acc_in;
   hex_flags_type       hex_flags_ff, hex_flags_in;
   status_type          error_ff, error_in;

   logic                delim, no_error, start, feed, close_delim, close_last, close_any;
   logic                err_many, err_long, is_digit, pos_one;
   logic [ACC_W-1:0]    base_mag, base_hex, mag_times_ten;
   dec_flags_type       base_dflags;
   hex_flags_type       base_hflags;
   logic [4:0]          hex_digit;
   logic                dec_ok, hex_ok;
   rsp_item_type        close_item, sum_item;

   always_comb begin
      delim    = is_delim(char_in);
      no_error = (error_ff == ST_OK);
      start    = no_error && !in_token_ff && !delim && (count_ff < MAX_COUNT);
      err_many = no_error && !in_token_ff && !delim && (count_ff >= MAX_COUNT);
      err_long = no_error && in_token_ff && !delim && (cur_length_ff >= MAX_CURLEN);
      close_delim = no_error && in_token_ff && delim;
      feed     = start || (no_error && in_token_ff && !delim && (cur_length_ff < MAX_CURLEN));

      base_mag    = start ? '0 : dec_mag_ff;
      base_dflags = start ? '0 : dec_flags_ff;
      base_hex    = start ? '0 : hex_acc_ff;
      base_hflags = start ? '0 : hex_flags_ff;
      pos_one     = !start && (cur_length_ff == CURLEN_W'(1));

      is_digit      = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
      mag_times_ten = (base_mag << 3) + (base_mag << 1) + ACC_W'(char_in[3:0]);
      hex_digit     = hex_value(char_in);

      dec_mag_in   = base_mag;
      dec_flags_in = base_dflags;
      hex_acc_in   = base_hex;
      hex_flags_in = base_hflags;

      if (start && (char_in == CHAR_PLUS || char_in == CHAR_MINUS)) begin
         if (char_in == CHAR_MINUS) begin
            dec_flags_in.neg = 1'b1;
         end
      end else if (is_digit) begin
         dec_flags_in.dig = 1'b1;
         if (!base_dflags.ovf) begin
            if (base_mag > DEC_MUL_LIMIT) begin
               dec_flags_in.ovf = 1'b1;
            end else begin
               dec_mag_in = mag_times_ten;
               if (mag_times_ten[ACC_W-1] && (|mag_times_ten[ACC_W-2:0])) begin
                  dec_flags_in.ovf = 1'b1;
               end
            end
         end
      end else begin
         dec_flags_in.bad = 1'b1;
      end

      if (start) begin
         if (char_in != CHAR_ZERO) begin
            hex_flags_in.bad = 1'b1;
         end
      end else if (pos_one) begin
         if (char_in != CHAR_X) begin
            hex_flags_in.bad = 1'b1;
         end
      end else if (hex_digit == HEX_NONE) begin
         hex_flags_in.bad = 1'b1;
      end else if (!base_hflags.ovf) begin
         if (|base_hex[ACC_W-1:ACC_W-4]) begin
            hex_flags_in.ovf = 1'b1;
         end else begin
            hex_acc_in = {base_hex[ACC_W-5:0], hex_digit[3:0]};
         end
      end

      if (!feed) begin
         dec_mag_in   = dec_mag_ff;
         dec_flags_in = dec_flags_ff;
         hex_acc_in   = hex_acc_ff;
         hex_flags_in = hex_flags_ff;
      end

      in_token_in   = start ? 1'b1 : (close_delim ? 1'b0 : in_token_ff);
      cur_length_in = start ? CURLEN_W'(1) :
                      (feed ? CURLEN_W'(cur_length_ff + 1'b1) : cur_length_ff);
      count_in      = start ? COUNT_W'(count_ff + 1'b1) : count_ff;
      error_in      = err_many ? ST_TOO_MANY : (err_long ? ST_TOO_LONG : error_ff);

      close_last = last_byte && in_token_in && (error_in == ST_OK);
      close_any  = close_delim || close_last;

      dec_ok = !dec_flags_in.bad && !dec_flags_in.ovf && dec_flags_in.dig &&
               !(dec_mag_in[ACC_W-1] && !dec_flags_in.neg);
      hex_ok = (cur_length_in > HEX_MIN_LEN) && !hex_flags_in.bad && !hex_flags_in.ovf;

      close_item.token_index  = INDEX_W'(count_in - 1'b1);
      close_item.token_length = LENGTH_W'(cur_length_in);
      close_item.status       = ST_OK;
      close_item.end_flag     = !last_byte;
      if (dec_ok) begin
         close_item.kind         = KIND_DEC;
         close_item.number_value = dec_flags_in.neg ? VALUE_W'(-dec_mag_in[VALUE_W-1:0]) :
                                                      dec_mag_in[VALUE_W-1:0];
      end else if (hex_ok) begin
         close_item.kind         = KIND_HEX;
         close_item.number_value = hex_acc_in[VALUE_W-1:0];
      end else begin
         close_item.kind         = KIND_STR;
         close_item.number_value = '0;
      end

      sum_item.kind         = KIND_SUM;
      sum_item.token_index  = INDEX_W'(count_in);
      sum_item.number_value = '0;
      sum_item.token_length = '0;
      sum_item.status       = error_in;
      sum_item.end_flag     = 1'b1;

      emit.first_valid  = accept && (close_any || last_byte);
      emit.second_valid = accept && close_any && last_byte;
      emit.first        = close_any ? close_item : sum_item;
      emit.second       = sum_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff   <= 1'b0;
         cur_length_ff <= '0;
         count_ff      <= '0;
         dec_flags_ff  <= '0;
         hex_flags_ff  <= '0;
         error_ff      <= ST_OK;
      end else if (accept) begin
         if (last_byte) begin
            in_token_ff   <= 1'b0;
            cur_length_ff <= '0;
            count_ff      <= '0;
            dec_flags_ff  <= '0;
            hex_flags_ff  <= '0;
            error_ff      <= ST_OK;
         end else begin
            in_token_ff   <= in_token_in;
            cur_length_ff <= cur_length_in;
            count_ff      <= count_in;
            dec_flags_ff  <= dec_flags_in;
            hex_flags_ff  <= hex_flags_in;
            error_ff      <= error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dec_mag_ff <= dec_mag_in;
         hex_acc_ff <= hex_acc_in;
      end
   end

endmodule

// ===== rtl/dtc_rsp_fifo.sv =====
`timescale 1ns / 1ps
// Four-entry result queue that takes up to two items per cycle and delivers one while the consumer is ready.
module dtc_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  dtc_pkg::emit_type     emit,
   output logic                  space_ok,
   output logic                  out_valid,
   input  logic                  out_ready,
   output dtc_pkg::rsp_item_type out_item
);
   import dtc_pkg::*;

   rsp_item_type           entry_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic [RSP_PTR_W-1:0]   wr_next;
   logic [RSP_CNT_W-1:0]   push_n;
   logic                   pop;

   always_comb begin
      out_valid = (count_ff != '0);
      out_item  = entry_ff[rd_ptr_ff];
      space_ok  = (count_ff <= RSP_CNT_W'(RSP_FIFO_DEPTH - 2));
      pop       = out_valid && out_ready;
      push_n    = RSP_CNT_W'(emit.first_valid) + RSP_CNT_W'(emit.second_valid);
      wr_next   = RSP_PTR_W'(wr_ptr_ff + 1'b1);
      wr_ptr_in = RSP_PTR_W'(wr_ptr_ff + push_n);
      rd_ptr_in = pop ? RSP_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = RSP_CNT_W'(count_ff + push_n - RSP_CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.first_valid) begin
         entry_ff[wr_ptr_ff] <= emit.first;
      end
      if (emit.second_valid) begin
         entry_ff[wr_next] <= emit.second;
      end
   end

endmodule

// ===== rtl/dtc_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the delimited token classifier and their bind.
module dtc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [4:0]  rsp_token_index,
   input logic [31:0] rsp_number_value,
   input logic [7:0]  rsp_token_length,
   input logic [1:0]  rsp_status,
   input logic        rsp_end_flag
);
   import dtc_pkg::*;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_token_index) && $stable(rsp_number_value) &&
      $stable(rsp_token_length) && $stable(rsp_status) && $stable(rsp_end_flag))
      else $error("Result item changed while stalled.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result item shown right after reset.");

   a_summary_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SUM) |->
      rsp_end_flag && (rsp_token_length == '0) && (rsp_number_value == '0))
      else $error("Summary item is malformed.");

   a_token_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_SUM) |->
      (rsp_status == ST_OK) && (rsp_token_length != '0))
      else $error("Token item has a status or an empty length.");

   a_string_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_STR) |-> (rsp_number_value == '0))
      else $error("String token carries a number value.");

endmodule

bind delimited_token_classifier dtc_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_kind         (rsp_ch.kind),
   .rsp_token_index  (rsp_ch.token_index),
   .rsp_number_value (rsp_ch.number_value),
   .rsp_token_length (rsp_ch.token_length),
   .rsp_status       (rsp_ch.status),
   .rsp_end_flag     (rsp_ch.end_flag)
);
